[hdl/assert_macros.svh]
// Assertion macros used by the checker in rbm_chk.sv.
// Each macro expands to one labeled concurrent assertion clocked on a rising edge.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion with an active-low reset that disables checking.
`define RBM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion that is checked in every cycle, reset included.
`define RBM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[hdl/rbm_pkg.sv]
// Shared types, codes and constants of the RSA block exponentiation engine.
// Depends on nothing; every other .sv file in hdl uses it by scoped names.
`timescale 1ns / 1ps
package rbm_pkg;
  localparam int KEY_BITS_DEF = 32;
  localparam int BLOCK_W      = 32;
  localparam int STEP_CNT_W   = 5;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 2'd2;

  typedef struct packed {
    logic [31:0] block;
    logic        tail_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] value;
    logic        passed_through;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RUN,
    ST_SAVE,
    ST_SETUP_SQR,
    ST_SETUP_MUL,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PH_REDUCE,
    PH_SQR,
    PH_MUL
  } phase_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic init_sqr;
    logic init_mul;
    logic step;
    logic save_base;
    logic save_acc;
    logic shift_exp;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic tail;
    logic n_small;
    logic exp_bit;
  } sts_t;
endpackage

[hdl/rbm_ctrl.sv]
// Sequencer of the RSA block engine: reduce, then per exponent bit square, and multiply when set.
// Depends on rbm_pkg; drives rbm_dpath through cmd_t and reads sts_t.
`timescale 1ns / 1ps
module rbm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  rbm_pkg::sts_t sts,
  output rbm_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done
);
  localparam logic [rbm_pkg::STEP_CNT_W-1:0] LAST = rbm_pkg::STEP_CNT_W'(rbm_pkg::BLOCK_W - 1);

  rbm_pkg::ctrl_state_t state_r, state_nxt;
  rbm_pkg::phase_t      phase_r, phase_nxt;
  logic [rbm_pkg::STEP_CNT_W-1:0] step_cnt_r, step_cnt_nxt;
  logic [rbm_pkg::STEP_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;

  // Hold state, phase and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rbm_pkg::ST_IDLE;
      phase_r    <= rbm_pkg::PH_REDUCE;
      step_cnt_r <= '0;
      bit_cnt_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      phase_r    <= phase_nxt;
      step_cnt_r <= step_cnt_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    step_cnt_nxt = step_cnt_r;
    bit_cnt_nxt  = bit_cnt_r;
    cmd          = '0;
    busy         = 1'b1;
    done         = 1'b0;
    case (state_r)
      rbm_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = rbm_pkg::ST_DISPATCH;
        end
      end
      rbm_pkg::ST_DISPATCH: begin
        step_cnt_nxt = '0;
        bit_cnt_nxt  = '0;
        phase_nxt    = rbm_pkg::PH_REDUCE;
        if (sts.tail || sts.n_small) state_nxt = rbm_pkg::ST_DONE;
        else state_nxt = rbm_pkg::ST_RUN;
      end
      rbm_pkg::ST_RUN: begin
        cmd.step     = 1'b1;
        step_cnt_nxt = step_cnt_r + 1'b1;
        if (step_cnt_r == LAST) state_nxt = rbm_pkg::ST_SAVE;
      end
      rbm_pkg::ST_SAVE: begin
        step_cnt_nxt = '0;
        case (phase_r)
          rbm_pkg::PH_REDUCE: begin
            cmd.save_base = 1'b1;
            state_nxt     = rbm_pkg::ST_SETUP_SQR;
          end
          rbm_pkg::PH_SQR: begin
            cmd.save_acc = 1'b1;
            if (sts.exp_bit) begin
              state_nxt = rbm_pkg::ST_SETUP_MUL;
            end else begin
              cmd.shift_exp = 1'b1;
              bit_cnt_nxt   = bit_cnt_r + 1'b1;
              state_nxt = (bit_cnt_r == LAST) ? rbm_pkg::ST_DONE : rbm_pkg::ST_SETUP_SQR;
            end
          end
          default: begin
            cmd.save_acc  = 1'b1;
            cmd.shift_exp = 1'b1;
            bit_cnt_nxt   = bit_cnt_r + 1'b1;
            state_nxt = (bit_cnt_r == LAST) ? rbm_pkg::ST_DONE : rbm_pkg::ST_SETUP_SQR;
          end
        endcase
      end
      rbm_pkg::ST_SETUP_SQR: begin
        cmd.init_sqr = 1'b1;
        phase_nxt    = rbm_pkg::PH_SQR;
        state_nxt    = rbm_pkg::ST_RUN;
      end
      rbm_pkg::ST_SETUP_MUL: begin
        cmd.init_mul = 1'b1;
        phase_nxt    = rbm_pkg::PH_MUL;
        state_nxt    = rbm_pkg::ST_RUN;
      end
      rbm_pkg::ST_DONE: begin
        done      = 1'b1;
        state_nxt = rbm_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rbm_pkg::ST_IDLE;
      end
    endcase
  end
endmodule

[hdl/rbm_dpath.sv]
// Datapath of the RSA block engine: bit-serial modular multiplier, base, accumulator.
// Depends on rbm_pkg; commanded by rbm_ctrl.
`timescale 1ns / 1ps
module rbm_dpath #(
  parameter int KEY_BITS = rbm_pkg::KEY_BITS_DEF
) (
  input  logic          clk,
  input  rbm_pkg::cmd_t cmd,
  input  rbm_pkg::in_t  in_data,
  input  logic [31:0]   modulus,
  input  logic [31:0]   exponent,
  input  logic          direction,
  output rbm_pkg::sts_t sts,
  output rbm_pkg::out_t out_data
);
  logic [KEY_BITS-1:0] n;
  logic [KEY_BITS:0]   n_ext, dbl, dbl_red, sum, sum_red, r_sel;
  logic [KEY_BITS-1:0] r_r, a_r, acc_r, base_r;
  logic [rbm_pkg::BLOCK_W-1:0] b_r, exp_r;
  logic                tail_r, dir_r;
  logic [7:0]          byte_r;

  assign n     = modulus[KEY_BITS-1:0];
  assign n_ext = {1'b0, n};

  // One multiplier bit: double mod n, then add multiplicand mod n when the multiplier bit is set
  always_comb begin
    dbl     = {r_r, 1'b0};
    dbl_red = (dbl >= n_ext) ? dbl - n_ext : dbl;
    sum     = dbl_red + {1'b0, a_r};
    sum_red = (sum >= n_ext) ? sum - n_ext : sum;
    r_sel   = b_r[rbm_pkg::BLOCK_W-1] ? sum_red : dbl_red;
  end

  // Load operands, advance the multiplier, save products, shift the exponent
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tail_r <= in_data.tail_byte;
      dir_r  <= direction;
      byte_r <= in_data.block[7:0];
      exp_r  <= exponent;
      acc_r  <= KEY_BITS'(1);
      r_r    <= '0;
      a_r    <= KEY_BITS'(1);
      b_r    <= direction ? in_data.block : {16'h0000, in_data.block[15:0]};
    end else if (cmd.init_sqr) begin
      r_r <= '0;
      a_r <= acc_r;
      b_r <= rbm_pkg::BLOCK_W'(acc_r);
    end else if (cmd.init_mul) begin
      r_r <= '0;
      a_r <= acc_r;
      b_r <= rbm_pkg::BLOCK_W'(base_r);
    end else if (cmd.step) begin
      r_r <= r_sel[KEY_BITS-1:0];
      b_r <= {b_r[rbm_pkg::BLOCK_W-2:0], 1'b0};
    end
    if (cmd.save_base) base_r <= r_r;
    if (cmd.save_acc) acc_r <= r_r;
    if (cmd.shift_exp) exp_r <= {exp_r[rbm_pkg::BLOCK_W-2:0], 1'b0};
  end

  assign sts.tail    = tail_r;
  assign sts.n_small = (n[KEY_BITS-1:1] == '0);
  assign sts.exp_bit = exp_r[rbm_pkg::BLOCK_W-1];

  // Select the result word
  always_comb begin
    out_data.passed_through = tail_r;
    if (tail_r) out_data.value = {24'h000000, byte_r};
    else if (sts.n_small) out_data.value = '0;
    else if (dir_r) out_data.value = {16'h0000, acc_r[15:0]};
    else out_data.value = 32'(acc_r);
  end
endmodule

[hdl/rsa_block_modexp.sv]
// Top level of the RSA block exponentiation engine: configuration registers,
// controller and datapath. Depends on rbm_pkg, rbm_ctrl and rbm_dpath.
`timescale 1ns / 1ps
// Usage:
//   Input channel: an item (block, tail_byte) is taken at a rising edge with
//   start high and busy low. busy stays high until the result has been shown.
//   Result channel: out_valid is high for exactly one cycle with out_data;
//   the receiver cannot stall, so the result must be taken in that cycle.
//   Configuration: cfg_we with cfg_index 0 (modulus), 1 (exponent) or
//   2 (direction) writes cfg_data at the edge; write only while idle.
// Sequence, counted from the accepting edge to the result:
//   A tail byte or a modulus below two: dispatch, then done.
//   Otherwise the multiplier first reduces the block, then for each of the
//   32 exponent bits, most significant first, squares the accumulator and,
//   when the bit is set, multiplies it by the base. The bit-serial modular
//   multiplier takes one multiplier bit per cycle.
//   A new item is accepted in the cycle after out_valid.
// Reset: rst_n low clears the controller to idle and the registers to
//   modulus all ones, exponent 1, direction encrypt.
module rsa_block_modexp #(
  parameter int KEY_BITS = rbm_pkg::KEY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  rbm_pkg::in_t                   in_data,
  output logic                           out_valid,
  output rbm_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [rbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);
  logic [31:0]   modulus_r, exponent_r;
  logic          direction_r;
  rbm_pkg::cmd_t cmd;
  rbm_pkg::sts_t sts;

  // Write configuration registers; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r   <= 32'hFFFF_FFFF;
      exponent_r  <= 32'd1;
      direction_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        rbm_pkg::CFG_MODULUS:   modulus_r   <= cfg_data;
        rbm_pkg::CFG_EXPONENT:  exponent_r  <= cfg_data;
        rbm_pkg::CFG_DIRECTION: direction_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rbm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (out_valid)
  );

  rbm_dpath #(.KEY_BITS(KEY_BITS)) u_dpath (
    .clk       (clk),
    .cmd       (cmd),
    .in_data   (in_data),
    .modulus   (modulus_r),
    .exponent  (exponent_r),
    .direction (direction_r),
    .sts       (sts),
    .out_data  (out_data)
  );
endmodule

[hdl/rbm_chk.sv]
// Port-level checker of the RSA block engine and its bind to the top level.
// Depends on rbm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rbm_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input rbm_pkg::in_t                  in_data,
  input logic                          out_valid,
  input rbm_pkg::out_t                 out_data,
  input logic                          cfg_we,
  input logic [rbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [31:0]                   cfg_data
);
  // A result is shown for a single cycle
  `RBM_ASSERT(a_one_cycle, clk, rst_n, out_valid |=> !out_valid, "result held too long")
  // An accepted item keeps the block busy
  `RBM_ASSERT(a_busy_after, clk, rst_n, (start && !busy) |=> busy, "busy not raised")
  // A result only comes from an item in flight
  `RBM_ASSERT(a_valid_busy, clk, rst_n, out_valid |-> busy, "result while idle")
  // A tail byte comes back straight after dispatch, marked and eight bits wide
  `RBM_ASSERT(a_tail, clk, rst_n,
    (start && !busy && in_data.tail_byte) |-> ##2 (out_valid && out_data.passed_through
    && (out_data.value[31:8] == 24'h0)), "tail byte result wrong")
  // Configuration is written only while idle, with known index and data
  `RBM_ASSERT(a_cfg_idle, clk, rst_n,
    cfg_we |-> (!busy && !$isunknown({cfg_index, cfg_data})), "config write while busy")
endmodule

bind rsa_block_modexp rbm_chk u_chk (.*);
